FILE: sv/ppsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional PID speed loop: shared types and constants
// Field widths, register indexes, reset values and the word formats passed
// between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package ppsl_pkg;

    localparam int PULSE_W     = 16;
    localparam int SETPOINT_W  = 16;
    localparam int GAIN_W      = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int DRIVE_W     = 16;
    localparam int ERROR_OUT_W = 32;

    // Internal ranges: speed = 3*pulse < 2^18, error in [-229373, 32767],
    // previous minus current error within +/-262140.
    localparam int SPEED_W = PULSE_W + 2;
    localparam int ERR_W   = SPEED_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int INTEG_W = 32;

    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + INTEG_W;
    localparam int PROD_D_W = GAIN_W + 1 + DIFF_W;
    localparam int SUM_W    = PROD_I_W + 2;

    localparam int GAIN_FRAC_BITS_DEFAULT = 20;
    localparam int QUEUE_DEPTH            = 2;

    localparam int DRIVE_MAX = 32767;
    localparam int DRIVE_MIN = -32768;

    localparam logic [SETPOINT_W-1:0] SPEED_SETPOINT_RST = 16'd2225;
    localparam logic [GAIN_W-1:0]     PROP_GAIN_RST      = 24'd50332;
    localparam logic [GAIN_W-1:0]     INTEGRAL_GAIN_RST  = 24'd304;
    localparam logic [GAIN_W-1:0]     DERIV_GAIN_RST     = 24'd10381;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SPEED_SETPOINT = 2'd0,
        REG_PROP_GAIN      = 2'd1,
        REG_INTEGRAL_GAIN  = 2'd2,
        REG_DERIV_GAIN     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SETPOINT_W-1:0] speed_setpoint;
        logic [GAIN_W-1:0]            prop_gain;
        logic [GAIN_W-1:0]            integral_gain;
        logic [GAIN_W-1:0]            deriv_gain;
    } cfg_t;

    // One queued word: the three PID terms of one sample
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DIFF_W-1:0]  diff;
    } term_t;

endpackage

FILE: sv/ppsl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional PID speed loop: front end
// Accepts pulse counts, forms the error, updates the saturating integral and
// the previous error, and pushes the three terms into the queue.
// ----------------------------------------------------------------------------
module ppsl_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic signed [ppsl_pkg::SETPOINT_W-1:0] speed_setpoint,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ppsl_pkg::PULSE_W-1:0]    s_pulse_count,
    output logic                            push_valid,
    input  logic                            push_ready,
    output ppsl_pkg::term_t                 push_data
);
    import ppsl_pkg::*;

    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [ERR_W-1:0]   prev_err_reg, prev_err_next;

    logic [SPEED_W-1:0]        speed;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W:0]   integ_wide;
    logic signed [INTEG_W-1:0] integ_sat;
    logic signed [DIFF_W-1:0]  diff;
    logic                      accept;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    always_comb begin
        speed      = {1'b0, s_pulse_count, 1'b0} + {2'b00, s_pulse_count};
        err        = {{(ERR_W-SETPOINT_W){speed_setpoint[SETPOINT_W-1]}}, speed_setpoint}
                   - $signed({1'b0, speed});
        integ_wide = {integ_reg[INTEG_W-1], integ_reg}
                   + {{(INTEG_W+1-ERR_W){err[ERR_W-1]}}, err};
        // clamp on signed overflow
        if (integ_wide[INTEG_W] != integ_wide[INTEG_W-1]) begin
            integ_sat = integ_wide[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                            : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            integ_sat = integ_wide[INTEG_W-1:0];
        end
        diff = {prev_err_reg[ERR_W-1], prev_err_reg} - {err[ERR_W-1], err};
    end

    always_comb begin
        integ_next    = integ_reg;
        prev_err_next = prev_err_reg;
        if (accept) begin
            integ_next    = integ_sat;
            prev_err_next = err;
        end
    end

    assign push_data.err   = err;
    assign push_data.integ = integ_sat;
    assign push_data.diff  = diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg    <= '0;
            prev_err_reg <= '0;
        end else begin
            integ_reg    <= integ_next;
            prev_err_reg <= prev_err_next;
        end
    end

endmodule

FILE: sv/ppsl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional PID speed loop: term queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module ppsl_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  ppsl_pkg::term_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output ppsl_pkg::term_t pop_data
);
    import ppsl_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    term_t              mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/ppsl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional PID speed loop: back end
// Three stages: gain products, product sum, truncation toward zero with
// saturation into the output register.
// ----------------------------------------------------------------------------
module ppsl_back #(
    parameter int GAIN_FRAC_BITS = ppsl_pkg::GAIN_FRAC_BITS_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  ppsl_pkg::cfg_t                         cfg,
    input  logic                                   pop_valid,
    output logic                                   pop_ready,
    input  ppsl_pkg::term_t                        pop_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [ppsl_pkg::DRIVE_W-1:0]     m_drive_value,
    output logic signed [ppsl_pkg::ERROR_OUT_W-1:0] m_speed_error
);
    import ppsl_pkg::*;

    localparam logic [SUM_W-1:0] ROUND_MASK =
        {{(SUM_W-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(DRIVE_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(DRIVE_MIN);

    // stage 1: products
    logic                       vld1_reg, vld1_next;
    logic signed [PROD_P_W-1:0] prod_p_reg;
    logic signed [PROD_I_W-1:0] prod_i_reg;
    logic signed [PROD_D_W-1:0] prod_d_reg;
    logic signed [ERR_W-1:0]    err1_reg;
    // stage 2: sum
    logic                       vld2_reg, vld2_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [ERR_W-1:0]    err2_reg;
    // stage 3: output
    logic                       vld3_reg, vld3_next;
    logic signed [DRIVE_W-1:0]  drive_reg, drive_next;
    logic signed [ERR_W-1:0]    err3_reg;

    logic                       adv1, adv2, adv3;
    logic signed [SUM_W-1:0]    sum_adj, quot;

    // advance a stage when it is empty or the next one takes its word
    assign adv3      = !vld3_reg || m_ready;
    assign adv2      = !vld2_reg || adv3;
    assign adv1      = !vld1_reg || adv2;
    assign pop_ready = adv1;

    always_comb begin
        vld1_next = adv1 ? pop_valid : vld1_reg;
        vld2_next = adv2 ? vld1_reg : vld2_reg;
        vld3_next = adv3 ? vld2_reg : vld3_reg;

        sum_next = {{(SUM_W-PROD_P_W){prod_p_reg[PROD_P_W-1]}}, prod_p_reg}
                 + {{(SUM_W-PROD_I_W){prod_i_reg[PROD_I_W-1]}}, prod_i_reg}
                 + {{(SUM_W-PROD_D_W){prod_d_reg[PROD_D_W-1]}}, prod_d_reg};

        // bias negative sums so the arithmetic shift truncates toward zero
        sum_adj = sum_reg + (sum_reg[SUM_W-1] ? $signed(ROUND_MASK) : $signed({SUM_W{1'b0}}));
        quot    = sum_adj >>> GAIN_FRAC_BITS;
        if (quot > SAT_HI) begin
            drive_next = SAT_HI[DRIVE_W-1:0];
        end else if (quot < SAT_LO) begin
            drive_next = SAT_LO[DRIVE_W-1:0];
        end else begin
            drive_next = quot[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && pop_valid) begin
            prod_p_reg <= PROD_P_W'($signed({1'b0, cfg.prop_gain}))
                        * PROD_P_W'(pop_data.err);
            prod_i_reg <= PROD_I_W'($signed({1'b0, cfg.integral_gain}))
                        * PROD_I_W'(pop_data.integ);
            prod_d_reg <= PROD_D_W'($signed({1'b0, cfg.deriv_gain}))
                        * PROD_D_W'(pop_data.diff);
            err1_reg   <= pop_data.err;
        end
        if (adv2 && vld1_reg) begin
            sum_reg  <= sum_next;
            err2_reg <= err1_reg;
        end
        if (adv3 && vld2_reg) begin
            drive_reg <= drive_next;
            err3_reg  <= err2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else begin
            vld1_reg <= vld1_next;
            vld2_reg <= vld2_next;
            vld3_reg <= vld3_next;
        end
    end

    assign m_valid       = vld3_reg;
    assign m_drive_value = drive_reg;
    assign m_speed_error = {{(ERROR_OUT_W-ERR_W){err3_reg[ERR_W-1]}}, err3_reg};

endmodule

FILE: sv/positional_pid_speed_loop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional PID speed loop
// Turns per-period encoder pulse counts into a saturated PWM drive value.
// ----------------------------------------------------------------------------
// Takes one pulse count per clock and returns one word per count, in order:
// speed error = setpoint - 3*count, and drive = kp*error + ki*integral +
// kd*(previous error - error), gains unsigned with GAIN_FRAC_BITS fraction
// bits, truncated toward zero and saturated to signed 16 bits. The integral
// saturates at the signed 32-bit limits. Sustained rate is one word per cycle
// while m_ready stays high; the integral update is a single add and clamp done
// as each count is taken. An accepted count's terms are written into the
// two-entry queue, then the back end registers in turn the three gain
// products, their sum, and the truncate/saturate output register.
// Backpressure on m_ready stalls the back end; the queue then fills and drops
// s_ready. Write configuration registers only while no word is in flight.
module positional_pid_speed_loop #(
    parameter int GAIN_FRAC_BITS = ppsl_pkg::GAIN_FRAC_BITS_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [ppsl_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [ppsl_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [ppsl_pkg::PULSE_W-1:0]            s_pulse_count,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [ppsl_pkg::DRIVE_W-1:0]     m_drive_value,
    output logic signed [ppsl_pkg::ERROR_OUT_W-1:0] m_speed_error
);
    import ppsl_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  push_valid, push_ready, pop_valid, pop_ready;
    term_t push_data, pop_data;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_SPEED_SETPOINT: cfg_next.speed_setpoint = cfg_wdata[SETPOINT_W-1:0];
                REG_PROP_GAIN:      cfg_next.prop_gain      = cfg_wdata[GAIN_W-1:0];
                REG_INTEGRAL_GAIN:  cfg_next.integral_gain  = cfg_wdata[GAIN_W-1:0];
                REG_DERIV_GAIN:     cfg_next.deriv_gain     = cfg_wdata[GAIN_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_setpoint <= SPEED_SETPOINT_RST;
            cfg_reg.prop_gain      <= PROP_GAIN_RST;
            cfg_reg.integral_gain  <= INTEGRAL_GAIN_RST;
            cfg_reg.deriv_gain     <= DERIV_GAIN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ppsl_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .speed_setpoint (cfg_reg.speed_setpoint),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pulse_count  (s_pulse_count),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_data      (push_data)
    );

    ppsl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ppsl_back #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive_value (m_drive_value),
        .m_speed_error (m_speed_error)
    );

endmodule

FILE: test/positional_pid_speed_loop_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional PID speed loop testbench
// Drives pulse counts through the speed loop and checks each drive word,
// drive value and speed error, against a cycle-free predictor of the PID
// arithmetic. It runs a directed table of extremes, then random phases under
// several register settings, with random stalls on both channels but in phase 3.
// ----------------------------------------------------------------------------
module positional_pid_speed_loop_tb;
    import ppsl_pkg::*;

    localparam int FRAC_BITS   = GAIN_FRAC_BITS_DEFAULT;
    localparam int QUIET_LIMIT = 1000;
    localparam int PLAN_LEN    = 38;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 225;

    localparam longint INTEG_MAX = 64'sd2147483647;
    localparam longint INTEG_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [DRIVE_W-1:0]     drive;
        logic signed [ERROR_OUT_W-1:0] speed_error;
    } drive_word_t;

    typedef enum logic {ROW_PULSE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t                     kind;
        cfg_reg_t                      index;
        logic [CFG_DATA_W-1:0]         value;
        logic [PULSE_W-1:0]            pulse;
        bit                            pinned;
        logic signed [DRIVE_W-1:0]     drive;
        logic signed [ERROR_OUT_W-1:0] speed_error;
    } plan_row_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [CFG_INDEX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]           cfg_wdata;
    logic                            s_valid;
    logic                            s_ready;
    logic [PULSE_W-1:0]              s_pulse_count;
    logic                            m_valid;
    logic                            m_ready;
    logic signed [DRIVE_W-1:0]       m_drive_value;
    logic signed [ERROR_OUT_W-1:0]   m_speed_error;

    // Predictor copy of the registers and loop state
    logic signed [SETPOINT_W-1:0]    setpoint_now;
    logic [GAIN_W-1:0]               kp_now;
    logic [GAIN_W-1:0]               ki_now;
    logic [GAIN_W-1:0]               kd_now;
    logic signed [INTEG_W-1:0]       integral_acc;
    logic signed [ERROR_OUT_W-1:0]   last_error;

    drive_word_t                     drive_words_due[$];
    plan_row_t                       plan [PLAN_LEN];
    int                              idle_pct;
    int                              mismatches;
    int                              quiet_cycles;

    positional_pid_speed_loop #(
        .GAIN_FRAC_BITS(FRAC_BITS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pulse_count (s_pulse_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive_value (m_drive_value),
        .m_speed_error (m_speed_error)
    );

    always #5 aclk = ~aclk;

    function automatic plan_row_t pulse_row(input logic [PULSE_W-1:0] pulse);
        plan_row_t r;
        r = '{ROW_PULSE, REG_SPEED_SETPOINT, '0, pulse, 1'b0, '0, '0};
        return r;
    endfunction

    function automatic plan_row_t pinned_row(input logic [PULSE_W-1:0] pulse,
                                             input int drive, input int speed_error);
        plan_row_t r;
        r = '{ROW_PULSE, REG_SPEED_SETPOINT, '0, pulse, 1'b1,
              drive[DRIVE_W-1:0], speed_error};
        return r;
    endfunction

    function automatic plan_row_t write_row(input cfg_reg_t index,
                                            input logic [CFG_DATA_W-1:0] value);
        plan_row_t r;
        r = '{ROW_WRITE, index, value, '0, 1'b0, '0, '0};
        return r;
    endfunction

    function automatic logic [GAIN_W-1:0] any_gain();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(1 << 17));
        endcase
    endfunction

    // Advance the loop by one pulse count and form its drive word
    function automatic void pid_update(input logic [PULSE_W-1:0] pulse,
                                       output drive_word_t w);
        longint err;
        longint integ;
        longint diff;
        longint sum;
        longint drive;
        err   = longint'(setpoint_now) - 3 * longint'(pulse);
        integ = longint'(integral_acc) + err;
        if (integ > INTEG_MAX) integ = INTEG_MAX;
        if (integ < INTEG_MIN) integ = INTEG_MIN;
        diff  = longint'(last_error) - err;
        sum   = longint'(kp_now) * err + longint'(ki_now) * integ
              + longint'(kd_now) * diff;
        // signed division truncates toward zero
        drive = sum / (longint'(1) << FRAC_BITS);
        if (drive > DRIVE_MAX) drive = DRIVE_MAX;
        if (drive < DRIVE_MIN) drive = DRIVE_MIN;
        integral_acc  = integ[INTEG_W-1:0];
        last_error    = err[ERROR_OUT_W-1:0];
        w.drive       = drive[DRIVE_W-1:0];
        w.speed_error = err[ERROR_OUT_W-1:0];
    endfunction

    // Leaves valid high; a register write or an idle gap in the next call lowers it
    task automatic send_pulse(input logic [PULSE_W-1:0] pulse, input bit pinned = 1'b0,
                              input logic signed [DRIVE_W-1:0] pin_drive = '0,
                              input logic signed [ERROR_OUT_W-1:0] pin_error = '0);
        drive_word_t w;
        cfg_wr_en <= 1'b0;
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pulse_count <= pulse;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pid_update(pulse, w);
        if (pinned) begin
            w.drive       = pin_drive;
            w.speed_error = pin_error;
        end
        drive_words_due.push_back(w);
    endtask

    // Hold off until every word in flight has come out, then write
    task automatic write_reg(input cfg_reg_t index, input logic [CFG_DATA_W-1:0] value);
        s_valid <= 1'b0;
        while (drive_words_due.size() != 0) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        case (index)
            REG_SPEED_SETPOINT: setpoint_now = value[SETPOINT_W-1:0];
            REG_PROP_GAIN:      kp_now       = value;
            REG_INTEGRAL_GAIN:  ki_now       = value;
            REG_DERIV_GAIN:     kd_now       = value;
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        drive_word_t head;
        m_ready <= ($urandom_range(99) >= idle_pct);
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (drive_words_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("drive word with none due: drive %0d error %0d",
                             m_drive_value, m_speed_error);
            end else begin
                head = drive_words_due.pop_front();
                if (m_drive_value !== head.drive || m_speed_error !== head.speed_error) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("drive word mismatch: expected drive %0d error %0d,",
                                 head.drive, head.speed_error,
                                 " got drive %0d error %0d", m_drive_value, m_speed_error);
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("positional_pid_speed_loop test failed");
        $finish;
    end

    initial begin
        logic signed [SETPOINT_W-1:0] sp;
        logic [GAIN_W-1:0]            kp;
        logic [GAIN_W-1:0]            ki;
        logic [GAIN_W-1:0]            kd;
        logic [CFG_DATA_W-1:0]        sp_word;
        logic [PULSE_W-1:0]           pulse;
        int                           near;

        aclk          = 1'b0;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_SPEED_SETPOINT;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_pulse_count = '0;
        m_ready       = 1'b0;
        idle_pct      = 28;
        mismatches    = 0;
        quiet_cycles  = 0;
        setpoint_now  = SPEED_SETPOINT_RST;
        kp_now        = PROP_GAIN_RST;
        ki_now        = INTEGRAL_GAIN_RST;
        kd_now        = DERIV_GAIN_RST;
        integral_acc  = '0;
        last_error    = '0;

        plan = '{
            pinned_row(16'd0, 85, 2225),            // first sample after reset
            pulse_row(16'hFFFF),
            pulse_row(16'd741),
            pulse_row(16'd742),
            write_row(REG_INTEGRAL_GAIN, 24'd0),
            write_row(REG_DERIV_GAIN, 24'd0),
            write_row(REG_PROP_GAIN, 24'hFFFFFF),
            write_row(REG_SPEED_SETPOINT, 24'h008000),
            pinned_row(16'hFFFF, -32768, -229373),   // deepest error, drive clipped low
            write_row(REG_SPEED_SETPOINT, 24'h007FFF),
            pinned_row(16'd0, 32767, 32767),         // drive clipped high
            write_row(REG_PROP_GAIN, 24'd1),
            write_row(REG_SPEED_SETPOINT, 24'd0),
            pinned_row(16'd1, 0, -3),                // small negative sum rounds to zero
            write_row(REG_SPEED_SETPOINT, 24'd3),
            pinned_row(16'd0, 0, 3),
            write_row(REG_PROP_GAIN, 24'h100000),
            write_row(REG_SPEED_SETPOINT, 24'd0),
            pinned_row(16'd5, -15, -15),
            write_row(REG_SPEED_SETPOINT, 24'hAB0005), // upper byte dropped
            pinned_row(16'd0, 5, 5),
            write_row(REG_PROP_GAIN, 24'd0),
            write_row(REG_INTEGRAL_GAIN, 24'h100000),
            pulse_row(16'd100),
            pulse_row(16'd0),
            write_row(REG_INTEGRAL_GAIN, 24'd0),
            write_row(REG_DERIV_GAIN, 24'h100000),
            pulse_row(16'd10),
            pulse_row(16'd20),
            write_row(REG_PROP_GAIN, 24'hFFFFFF),
            write_row(REG_INTEGRAL_GAIN, 24'hFFFFFF),
            write_row(REG_DERIV_GAIN, 24'hFFFFFF),
            write_row(REG_SPEED_SETPOINT, 24'h008000),
            pulse_row(16'hFFFF),
            pulse_row(16'd0),
            write_row(REG_SPEED_SETPOINT, 24'h007FFF),
            pulse_row(16'd0),
            pulse_row(16'hFFFF)
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE)
                write_reg(plan[i].index, plan[i].value);
            else
                send_pulse(plan[i].pulse, plan[i].pinned, plan[i].drive,
                           plan[i].speed_error);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            idle_pct = (phase == 3) ? 0 : 28;
            case (phase)
                0: begin
                    sp = 16'sh8000;
                    kp = '1;
                    ki = '1;
                    kd = '1;
                end
                1: begin
                    sp = 16'sh7FFF;
                    kp = '0;
                    ki = '0;
                    kd = '0;
                end
                default: begin
                    case ($urandom_range(3))
                        0: sp = 16'sh8000;
                        1: sp = 16'sh7FFF;
                        2: sp = SETPOINT_W'($urandom);
                        default: sp = SETPOINT_W'($urandom_range(6000));
                    endcase
                    kp = any_gain();
                    ki = any_gain();
                    kd = any_gain();
                end
            endcase
            sp_word = CFG_DATA_W'($urandom);
            sp_word[SETPOINT_W-1:0] = sp;
            write_reg(REG_SPEED_SETPOINT, sp_word);
            write_reg(REG_PROP_GAIN, kp);
            write_reg(REG_INTEGRAL_GAIN, ki);
            write_reg(REG_DERIV_GAIN, kd);
            repeat (PHASE_ITEMS) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: begin
                        // hover around the balance point, as a closed loop would
                        near = (sp > 0 ? int'(sp) / 3 : 0) + int'($urandom_range(200)) - 100;
                        pulse = (near < 0) ? 16'd0 : near[PULSE_W-1:0];
                    end
                    4, 5:    pulse = PULSE_W'($urandom);
                    6, 7:    pulse = PULSE_W'($urandom_range(1000));
                    8:       pulse = 16'd0;
                    default: pulse = 16'hFFFF;
                endcase
                send_pulse(pulse);
            end
        end

        s_valid <= 1'b0;
        while (drive_words_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("positional_pid_speed_loop test passed");
        else
            $display("positional_pid_speed_loop test failed");
        $finish;
    end

endmodule

FILE: positional_pid_speed_loop.f
sv/ppsl_pkg.sv
sv/ppsl_front.sv
sv/ppsl_queue.sv
sv/ppsl_back.sv
sv/positional_pid_speed_loop.sv
test/positional_pid_speed_loop_tb.sv
